FILE: rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the SQL token lexer
// Event, kind and error codes, lexer modes, character codes and the bundle
// that carries all results of one input transaction through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    // Queue depth between front and back (power of two, 2 or more)
    localparam int QUEUE_DEPTH = 4;

    // Most results that one input transaction can cause
    localparam int MAX_RESULTS = 4;

    // Result event codes
    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_EOI  = 2'd2;
    localparam logic [1:0] EV_ERR  = 2'd3;

    // Token kinds
    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_OP    = 3'd3;
    localparam logic [2:0] K_PUNCT = 3'd4;
    localparam logic [2:0] K_END   = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_UNEXP = 2'd2;

    // Operator first-character indexes
    localparam logic [1:0] OPC_LT = 2'd0;
    localparam logic [1:0] OPC_GT = 2'd1;
    localparam logic [1:0] OPC_EQ = 2'd2;
    localparam logic [1:0] OPC_NE = 2'd3;

    // Character codes
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_OP     = 3'd4,
        MODE_ERROR  = 3'd5
    } t_mode;

    // One result event
    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } t_event;

    // All results of one input transaction, in order
    typedef struct packed {
        logic [2:0]                   cnt;
        t_event [MAX_RESULTS-1:0]     evs;
    } t_bundle;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: rtl/core/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: lexer front end
// Classifies each input byte against the current lexer mode, updates the
// mode, and packs every result of the transaction into one queue bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front
    import stl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_query,
    output logic            o_stall,
    input  wire t_q_stat    i_q_stat,
    output logic            o_push,
    output t_bundle         o_bundle
);

    // Result of lexing one byte from the idle mode
    typedef struct packed {
        t_event     e0;
        logic       v0;
        t_event     e1;
        logic       v1;
        t_mode      mode;
        logic       q_set;
        logic       quote;
        logic       o_set;
        logic [1:0] opc;
        logic       pexp_clr;
    } t_idle_res;

    function automatic t_event mk_ev(logic [1:0] ev, logic [2:0] kind,
                                     logic [7:0] data, logic [1:0] err);
        t_event e;
        e.ev   = ev;
        e.kind = kind;
        e.data = data;
        e.err  = err;
        return e;
    endfunction

    function automatic t_idle_res lex_idle(logic [7:0] c);
        t_idle_res r;
        logic      sp;
        logic      dig;
        logic      alp;
        r          = '0;
        r.mode     = MODE_IDLE;
        sp  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        dig = (c >= CH_0) && (c <= CH_9);
        alp = ((c >= CH_A_LO) && (c <= CH_Z_LO)) || ((c >= CH_A_UP) && (c <= CH_Z_UP));
        if (sp) begin
            r.mode = MODE_IDLE;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r.mode  = MODE_STRING;
            r.q_set = 1'b1;
            r.quote = (c == CH_DQUOTE);
        end else if (dig) begin
            r.e0       = mk_ev(EV_BYTE, K_NUM, c, ERR_NONE);
            r.v0       = 1'b1;
            r.mode     = MODE_NUMBER;
            r.pexp_clr = 1'b1;
        end else if (alp || c == CH_UNDER) begin
            r.e0   = mk_ev(EV_BYTE, K_IDENT, c, ERR_NONE);
            r.v0   = 1'b1;
            r.mode = MODE_IDENT;
        end else if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG) begin
            r.e0    = mk_ev(EV_BYTE, K_OP, c, ERR_NONE);
            r.v0    = 1'b1;
            r.mode  = MODE_OP;
            r.o_set = 1'b1;
            if (c == CH_LT) begin
                r.opc = OPC_LT;
            end else if (c == CH_GT) begin
                r.opc = OPC_GT;
            end else if (c == CH_EQ) begin
                r.opc = OPC_EQ;
            end else begin
                r.opc = OPC_NE;
            end
        end else if (c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN ||
                     c == CH_STAR || c == CH_MINUS || c == CH_PLUS) begin
            r.e0   = mk_ev(EV_BYTE, K_PUNCT, c, ERR_NONE);
            r.v0   = 1'b1;
            r.e1   = mk_ev(EV_END, K_PUNCT, 8'd0, ERR_NONE);
            r.v1   = 1'b1;
            r.mode = MODE_IDLE;
        end else begin
            r.e0   = mk_ev(EV_ERR, K_IDENT, c, ERR_UNEXP);
            r.v0   = 1'b1;
            r.mode = MODE_ERROR;
        end
        return r;
    endfunction

    function automatic logic [2:0] kind_of(t_mode m);
        logic [2:0] k;
        case (m)
            MODE_IDENT:  k = K_IDENT;
            MODE_NUMBER: k = K_NUM;
            MODE_STRING: k = K_STR;
            default:     k = K_OP;
        endcase
        return k;
    endfunction

    t_mode      r_mode;
    logic       r_quote;
    logic [1:0] r_opc;
    logic       r_pexp;
    t_mode      n_mode;
    logic       n_quote;
    logic [1:0] n_opc;
    logic       n_pexp;

    t_mode      w_mid_mode;
    t_idle_res  w_idle;
    logic       w_accept;
    logic       w_is_e;
    logic       w_is_dig;
    logic       w_is_alp;
    logic       w_cont;
    logic       w_op_pair;
    logic       w_quote_hit;
    t_event     w_cand [5];
    logic [4:0] w_cand_v;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !o_stall;

    // Classify the incoming byte
    always_comb begin
        w_idle   = lex_idle(i_text_byte);
        w_is_e   = (i_text_byte == CH_E_LO) || (i_text_byte == CH_E_UP);
        w_is_dig = (i_text_byte >= CH_0) && (i_text_byte <= CH_9);
        w_is_alp = ((i_text_byte >= CH_A_LO) && (i_text_byte <= CH_Z_LO)) ||
                   ((i_text_byte >= CH_A_UP) && (i_text_byte <= CH_Z_UP));
        w_op_pair   = (i_text_byte == CH_EQ) || ((r_opc == OPC_LT) && (i_text_byte == CH_GT));
        w_quote_hit = (i_text_byte == (r_quote ? CH_DQUOTE : CH_SQUOTE));
        if (r_mode == MODE_IDENT) begin
            w_cont = w_is_alp || w_is_dig || i_text_byte == CH_UNDER || i_text_byte == CH_DOT;
        end else begin
            w_cont = w_is_dig || i_text_byte == CH_DOT || w_is_e ||
                     ((i_text_byte == CH_PLUS || i_text_byte == CH_MINUS) && r_pexp);
        end
    end

    // Next lexer state
    always_comb begin
        n_mode  = r_mode;
        n_quote = r_quote;
        n_opc   = r_opc;
        n_pexp  = r_pexp;
        if (i_has_byte) begin
            unique case (r_mode)
                MODE_STRING: begin
                    if (w_quote_hit) n_mode = MODE_IDLE;
                end
                MODE_IDENT, MODE_NUMBER: begin
                    if (w_cont) begin
                        if (r_mode == MODE_NUMBER) n_pexp = w_is_e;
                    end else begin
                        n_opc  = OPC_LT;
                        n_pexp = 1'b0;
                        n_mode = w_idle.mode;
                        if (w_idle.q_set) n_quote = w_idle.quote;
                        if (w_idle.o_set) n_opc = w_idle.opc;
                    end
                end
                MODE_OP: begin
                    n_opc = OPC_LT;
                    if (w_op_pair) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_pexp = 1'b0;
                        n_mode = w_idle.mode;
                        if (w_idle.q_set) n_quote = w_idle.quote;
                        if (w_idle.o_set) n_opc = w_idle.opc;
                    end
                end
                MODE_ERROR: begin
                    n_mode = MODE_ERROR;
                end
                default: begin
                    n_mode = w_idle.mode;
                    if (w_idle.q_set) n_quote = w_idle.quote;
                    if (w_idle.o_set) n_opc = w_idle.opc;
                    if (w_idle.pexp_clr) n_pexp = 1'b0;
                end
            endcase
        end
        w_mid_mode = n_mode;
        if (i_end_of_query) begin
            n_mode  = MODE_IDLE;
            n_quote = 1'b0;
            n_opc   = OPC_LT;
            n_pexp  = 1'b0;
        end
    end

    // Result events, slot 0 for the current token (slot 1 too for an operator
    // pair), 1-2 for the idle lex, 3-4 for the end of query
    always_comb begin
        for (int i = 0; i < 5; i++) w_cand[i] = '0;
        w_cand_v = '0;
        if (i_has_byte) begin
            unique case (r_mode)
                MODE_STRING: begin
                    w_cand_v[0] = 1'b1;
                    w_cand[0]   = w_quote_hit ? mk_ev(EV_END, K_STR, 8'd0, ERR_NONE)
                                              : mk_ev(EV_BYTE, K_STR, i_text_byte, ERR_NONE);
                end
                MODE_IDENT, MODE_NUMBER: begin
                    w_cand_v[0] = 1'b1;
                    if (w_cont) begin
                        w_cand[0] = mk_ev(EV_BYTE, kind_of(r_mode), i_text_byte, ERR_NONE);
                    end else begin
                        w_cand[0]   = mk_ev(EV_END, kind_of(r_mode), 8'd0, ERR_NONE);
                        w_cand[1]   = w_idle.e0;
                        w_cand_v[1] = w_idle.v0;
                        w_cand[2]   = w_idle.e1;
                        w_cand_v[2] = w_idle.v1;
                    end
                end
                MODE_OP: begin
                    w_cand_v[0] = 1'b1;
                    if (w_op_pair) begin
                        w_cand[0]   = mk_ev(EV_BYTE, K_OP, i_text_byte, ERR_NONE);
                        w_cand[1]   = mk_ev(EV_END, K_OP, 8'd0, ERR_NONE);
                        w_cand_v[1] = 1'b1;
                    end else begin
                        w_cand[0]   = mk_ev(EV_END, K_OP, 8'd0, ERR_NONE);
                        w_cand[1]   = w_idle.e0;
                        w_cand_v[1] = w_idle.v0;
                        w_cand[2]   = w_idle.e1;
                        w_cand_v[2] = w_idle.v1;
                    end
                end
                MODE_ERROR: begin
                    w_cand_v[0] = 1'b0;
                end
                default: begin
                    w_cand[1]   = w_idle.e0;
                    w_cand_v[1] = w_idle.v0;
                    w_cand[2]   = w_idle.e1;
                    w_cand_v[2] = w_idle.v1;
                end
            endcase
        end
        if (i_end_of_query) begin
            unique case (w_mid_mode)
                MODE_IDENT, MODE_NUMBER, MODE_OP: begin
                    w_cand[3]   = mk_ev(EV_END, kind_of(w_mid_mode), 8'd0, ERR_NONE);
                    w_cand_v[3] = 1'b1;
                    w_cand[4]   = mk_ev(EV_EOI, K_END, 8'd0, ERR_NONE);
                    w_cand_v[4] = 1'b1;
                end
                MODE_STRING: begin
                    w_cand[3]   = mk_ev(EV_ERR, K_IDENT, 8'd0, ERR_UNTERM);
                    w_cand_v[3] = 1'b1;
                end
                MODE_IDLE: begin
                    w_cand[4]   = mk_ev(EV_EOI, K_END, 8'd0, ERR_NONE);
                    w_cand_v[4] = 1'b1;
                end
                default: begin
                    w_cand_v[4] = 1'b0;
                end
            endcase
        end
    end

    // Pack valid events in order; at most four are ever valid together
    always_comb begin
        o_bundle = '0;
        for (int i = 0; i < 5; i++) begin
            if (w_cand_v[i]) begin
                o_bundle.evs[o_bundle.cnt[1:0]] = w_cand[i];
                o_bundle.cnt = o_bundle.cnt + 3'd1;
            end
        end
        o_push = w_accept && (o_bundle.cnt != 3'd0);
    end

    // Advance lexer state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_quote <= 1'b0;
            r_opc   <= OPC_LT;
            r_pexp  <= 1'b0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_opc   <= n_opc;
            r_pexp  <= n_pexp;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue: bundle queue between front and back
// Small register queue of result bundles; one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_queue
    import stl_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_bundle,
    input  wire logic    i_pop,
    output t_bundle      o_head,
    output t_q_stat      o_stat
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_bundle         r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == CW'(P_DEPTH));
    assign o_stat.not_empty = (r_count != '0);

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_bundle;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + AW'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: result sequencer
// Steps through the events of the head bundle, one per cycle unless stalled,
// into the output register and marks the last event of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_back
    import stl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    input  wire logic    i_stall,
    output logic         o_valid,
    output logic [1:0]   o_event_res,
    output logic [2:0]   o_token_kind,
    output logic [7:0]   o_out_byte,
    output logic [1:0]   o_error_code,
    output logic         o_last_result
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_event     r_ev;
    logic       r_last;
    logic       w_free;
    logic       w_load;
    logic       w_last;

    assign w_free = !r_valid || !i_stall;
    assign w_load = w_free && i_q_stat.not_empty;
    assign w_last = ({1'b0, r_idx} == (i_head.cnt - 3'd1));
    assign o_pop  = w_load && w_last;

    // Track position inside the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_free) r_valid <= i_q_stat.not_empty;
            if (w_load) r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ev   <= i_head.evs[r_idx];
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_res   = r_ev.ev;
    assign o_token_kind  = r_ev.kind;
    assign o_out_byte    = r_ev.data;
    assign o_error_code  = r_ev.err;
    assign o_last_result = r_last;

endmodule

`default_nettype wire

FILE: rtl/core/sql_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// sql_token_lexer_unit: streaming SQL token lexer
// Input channel (i_valid / o_stall): one transaction per text byte, with
// i_has_byte for a byte and i_end_of_query to close the query.
// Output channel (o_valid / i_stall): one transaction per token event:
// token byte, token end, end-of-input token or error, with o_last_result
// set on the final event caused by an input transaction.
// The edge that accepts a transaction updates the lexer state and writes its
// bundle into the queue; the output register then loads events from the head.
// Throughput: one input transaction per cycle while the queue has room; the
// output register sends one event per cycle unless the receiver stalls, and
// a transaction causes 0 to 4 events, sent one after another.
// Transactions that cause no event (whitespace, quote open, dropped bytes
// after an error) are absorbed without using the output.
// The queue holds P_QUEUE_DEPTH bundles; o_stall rises only when it is full.
// Reset: lexer returns to idle, queue and output register empty.
// When the receiver stalls, the output payload holds and the queue fills;
// the input keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_lexer_unit
    import stl_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_query,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_event_res,
    output logic [2:0]      o_token_kind,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_error_code,
    output logic            o_last_result
);

    t_q_stat w_q_stat;
    t_bundle w_push_bundle;
    t_bundle w_head;
    logic    w_push;
    logic    w_pop;

    // Classify bytes and build bundles
    stl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_text_byte    (i_text_byte),
        .i_has_byte     (i_has_byte),
        .i_end_of_query (i_end_of_query),
        .o_stall        (o_stall),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_bundle       (w_push_bundle)
    );

    // Decouple front and back
    stl_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_push_bundle),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_stat   (w_q_stat)
    );

    // Send events one at a time
    stl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_event_res   (o_event_res),
        .o_token_kind  (o_token_kind),
        .o_out_byte    (o_out_byte),
        .o_error_code  (o_error_code),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/stl_port_checker.sv
// ----------------------------------------------------------------------------
// stl_port_checker: port-level checks of the SQL token lexer
// Watches the top-level ports for reset behavior, output hold under stall
// and the field patterns of error, end-of-input and token end events.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_port_checker
    import stl_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_event_res,
    input wire logic [2:0] o_token_kind,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_error_code,
    input wire logic       o_last_result
);

    // Reset empties the output and frees the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) &&
        $stable(o_token_kind) && $stable(o_out_byte) &&
        $stable(o_error_code) && $stable(o_last_result))
        else $error("stalled result changed");

    // Error events carry a code and no kind
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_ERR |->
        o_token_kind == K_IDENT && o_error_code != ERR_NONE)
        else $error("bad error event fields");

    // End-of-input token closes its transaction
    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_EOI |->
        o_token_kind == K_END && o_last_result && o_out_byte == 8'd0)
        else $error("bad end-of-input event");

    // Token end carries no byte and no error
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_END |->
        o_out_byte == 8'd0 && o_error_code == ERR_NONE)
        else $error("bad token end event");

endmodule

bind sql_token_lexer_unit stl_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_event_res   (o_event_res),
    .o_token_kind  (o_token_kind),
    .o_out_byte    (o_out_byte),
    .o_error_code  (o_error_code),
    .o_last_result (o_last_result)
);

`default_nettype wire

FILE: verif/sql_token_lexer_unit_test.sv
// ----------------------------------------------------------------------------
// sql_token_lexer_unit_test: self-checking bench of the streaming SQL lexer
// Sends query text one byte per transaction. A directed table opens the
// run: extremes, every token class and operator, and the error paths.
// Random queries of well-formed tokens with some noise follow. Every
// accepted input runs through a local lexer model, and each output
// transaction is compared in order with the oldest predicted event. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------

module sql_token_lexer_unit_test;
    import stl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RAND_ITEMS   = 320;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // Kind field of an error event
    localparam logic [2:0] NO_KIND = 3'd0;

    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] kind;
        logic [7:0] data;
        logic [1:0] err;
        logic       last;
    } t_lex_event;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       eoq;
    } t_text_item;

    // Input transaction; typed rows carry their expected event (zero or one)
    typedef struct packed {
        t_text_item item;
        logic       typed;
        logic       n_res;
        t_lex_event res;
    } t_text_row;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_text_byte    = 8'h00;
    logic       i_has_byte     = 1'b0;
    logic       i_end_of_query = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_event_res;
    logic [2:0] o_token_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_error_code;
    logic       o_last_result;

    // Lexer model state
    t_mode      lex_mode = MODE_IDLE;
    logic       quote_dq = 1'b0;
    logic [1:0] op_first = OPC_LT;
    logic       exp_mark = 1'b0;

    t_lex_event  step_events[$];
    t_lex_event  pending_events[$];
    t_text_row   dir_rows[$];
    t_text_item  text_q[$];

    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned tx_calm      = 0;
    int unsigned rx_calm      = 0;
    int unsigned rx_hold      = 0;

    sql_token_lexer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .i_has_byte     (i_has_byte),
        .i_end_of_query (i_end_of_query),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_res    (o_event_res),
        .o_token_kind   (o_token_kind),
        .o_out_byte     (o_out_byte),
        .o_error_code   (o_error_code),
        .o_last_result  (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
    endfunction

    function automatic logic [2:0] mode_kind();
        case (lex_mode)
            MODE_IDENT:  return K_IDENT;
            MODE_NUMBER: return K_NUM;
            MODE_STRING: return K_STR;
            default:     return K_OP;
        endcase
    endfunction

    function automatic void add_event(logic [1:0] ev, logic [2:0] kind,
                                      logic [7:0] data, logic [1:0] err);
        t_lex_event r;
        r.ev   = ev;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        if (step_events.size() < MAX_RESULTS)
            step_events = {step_events, r};
    endfunction

    // Start a token from idle
    function automatic void lex_from_idle(logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return;
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            lex_mode = MODE_STRING;
            quote_dq = (c == CH_DQUOTE);
            return;
        end
        if (is_digit(c)) begin
            add_event(EV_BYTE, K_NUM, c, ERR_NONE);
            lex_mode = MODE_NUMBER;
            exp_mark = 1'b0;
            return;
        end
        if (is_alpha(c) || c == CH_UNDER) begin
            add_event(EV_BYTE, K_IDENT, c, ERR_NONE);
            lex_mode = MODE_IDENT;
            return;
        end
        case (c)
            CH_LT, CH_GT, CH_EQ, CH_BANG: begin
                add_event(EV_BYTE, K_OP, c, ERR_NONE);
                lex_mode = MODE_OP;
                op_first = (c == CH_LT) ? OPC_LT :
                           (c == CH_GT) ? OPC_GT :
                           (c == CH_EQ) ? OPC_EQ : OPC_NE;
            end
            CH_COMMA, CH_LPAREN, CH_RPAREN, CH_STAR, CH_MINUS, CH_PLUS: begin
                add_event(EV_BYTE, K_PUNCT, c, ERR_NONE);
                add_event(EV_END, K_PUNCT, 8'h00, ERR_NONE);
            end
            default: begin
                add_event(EV_ERR, NO_KIND, c, ERR_UNEXP);
                lex_mode = MODE_ERROR;
            end
        endcase
    endfunction

    // Advance the lexer by one text byte
    function automatic void lex_char(logic [7:0] c);
        bit cont;
        cont = 1'b0;
        case (lex_mode)
            MODE_IDLE: begin
                lex_from_idle(c);
                return;
            end
            MODE_STRING: begin
                if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                    add_event(EV_END, K_STR, 8'h00, ERR_NONE);
                    lex_mode = MODE_IDLE;
                end else begin
                    add_event(EV_BYTE, K_STR, c, ERR_NONE);
                end
                return;
            end
            MODE_IDENT: begin
                cont = is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
            end
            MODE_NUMBER: begin
                cont = is_digit(c) || c == CH_DOT || c == CH_E_LO || c == CH_E_UP ||
                       ((c == CH_PLUS || c == CH_MINUS) && exp_mark);
                if (cont)
                    exp_mark = (c == CH_E_LO || c == CH_E_UP);
            end
            MODE_OP: begin
                if (c == CH_EQ || (op_first == OPC_LT && c == CH_GT)) begin
                    add_event(EV_BYTE, K_OP, c, ERR_NONE);
                    add_event(EV_END, K_OP, 8'h00, ERR_NONE);
                    lex_mode = MODE_IDLE;
                    op_first = OPC_LT;
                    return;
                end
            end
            MODE_ERROR: begin
                return;
            end
            default: begin
                lex_mode = MODE_IDLE;
                lex_from_idle(c);
                return;
            end
        endcase
        if (cont) begin
            add_event(EV_BYTE, mode_kind(), c, ERR_NONE);
            return;
        end
        // Close the token, then lex the byte afresh
        add_event(EV_END, mode_kind(), 8'h00, ERR_NONE);
        lex_mode = MODE_IDLE;
        op_first = OPC_LT;
        exp_mark = 1'b0;
        lex_from_idle(c);
    endfunction

    // Close the query
    function automatic void lex_close();
        case (lex_mode)
            MODE_IDENT, MODE_NUMBER, MODE_OP: begin
                add_event(EV_END, mode_kind(), 8'h00, ERR_NONE);
                add_event(EV_EOI, K_END, 8'h00, ERR_NONE);
            end
            MODE_STRING: add_event(EV_ERR, NO_KIND, 8'h00, ERR_UNTERM);
            MODE_IDLE:   add_event(EV_EOI, K_END, 8'h00, ERR_NONE);
            default: ;
        endcase
        lex_mode = MODE_IDLE;
        quote_dq = 1'b0;
        op_first = OPC_LT;
        exp_mark = 1'b0;
    endfunction

    // Work out the events of one input transaction into step_events
    function automatic void lex_predict(t_text_item it);
        step_events.delete();
        if (it.has)
            lex_char(it.ch);
        if (it.eoq)
            lex_close();
        if (step_events.size() != 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Idle count per transaction, with calm stretches of no idling
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 16);
        return 0;
    endfunction

    function automatic void dir_plain(logic [7:0] ch, logic has, logic eoq);
        t_text_row row;
        row = '0;
        row.item.ch  = ch;
        row.item.has = has;
        row.item.eoq = eoq;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void dir_known(logic [7:0] ch, logic has, logic eoq, logic n_res,
                                      logic [1:0] ev, logic [2:0] kind,
                                      logic [7:0] data, logic [1:0] err);
        t_text_row row;
        row.item.ch  = ch;
        row.item.has = has;
        row.item.eoq = eoq;
        row.typed    = 1'b1;
        row.n_res    = n_res;
        row.res.ev   = ev;
        row.res.kind = kind;
        row.res.data = data;
        row.res.err  = err;
        row.res.last = 1'b1;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void push_text(logic [7:0] ch, logic has, logic eoq);
        t_text_item it;
        it.ch  = ch;
        it.has = has;
        it.eoq = eoq;
        text_q = {text_q, it};
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1) == 0)
            return CH_A_LO + 8'($urandom_range(0, 25));
        return CH_A_UP + 8'($urandom_range(0, 25));
    endfunction

    // Append one random query: mostly well-formed tokens, some noise
    function automatic void gen_query();
        int unsigned n_tok, k, j, len, first;
        logic [7:0]  q, b;
        first = text_q.size();
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            for (j = 0; j < len; j++)
                push_text(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end else begin
            n_tok = $urandom_range(1, 6);
            for (k = 0; k < n_tok; k++) begin
                if ($urandom_range(0, 1) == 0)
                    push_text(($urandom_range(0, 1) == 0) ? CH_SPACE :
                              CH_TAB + 8'($urandom_range(0, 4)), 1'b1, 1'b0);
                case ($urandom_range(0, 4))
                    0: begin
                        push_text(($urandom_range(0, 5) == 0) ? CH_UNDER : pick_letter(),
                                  1'b1, 1'b0);
                        len = $urandom_range(0, 5);
                        for (j = 0; j < len; j++) begin
                            case ($urandom_range(0, 3))
                                0: b = pick_letter();
                                1: b = CH_0 + 8'($urandom_range(0, 9));
                                2: b = CH_UNDER;
                                default: b = CH_DOT;
                            endcase
                            push_text(b, 1'b1, 1'b0);
                        end
                    end
                    1: begin
                        push_text(CH_0 + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
                        len = $urandom_range(0, 5);
                        for (j = 0; j < len; j++) begin
                            case ($urandom_range(0, 3))
                                0, 1: push_text(CH_0 + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
                                2: push_text(CH_DOT, 1'b1, 1'b0);
                                default: begin
                                    push_text(($urandom_range(0, 1) == 0) ? CH_E_LO : CH_E_UP,
                                              1'b1, 1'b0);
                                    if ($urandom_range(0, 1) == 0)
                                        push_text(($urandom_range(0, 1) == 0) ? CH_PLUS :
                                                  CH_MINUS, 1'b1, 1'b0);
                                end
                            endcase
                        end
                    end
                    2: begin
                        q = ($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE;
                        push_text(q, 1'b1, 1'b0);
                        len = $urandom_range(0, 6);
                        for (j = 0; j < len; j++) begin
                            b = ($urandom_range(0, 1) == 0) ? pick_letter() :
                                8'($urandom_range(0, 255));
                            if (b == q)
                                b = CH_DOT;
                            push_text(b, 1'b1, 1'b0);
                        end
                        // Leave some strings open
                        if ($urandom_range(0, 11) != 0)
                            push_text(q, 1'b1, 1'b0);
                    end
                    3: begin
                        case ($urandom_range(0, 3))
                            0: push_text(CH_LT, 1'b1, 1'b0);
                            1: push_text(CH_GT, 1'b1, 1'b0);
                            2: push_text(CH_EQ, 1'b1, 1'b0);
                            default: push_text(CH_BANG, 1'b1, 1'b0);
                        endcase
                        case ($urandom_range(0, 2))
                            0: push_text(CH_EQ, 1'b1, 1'b0);
                            1: push_text(CH_GT, 1'b1, 1'b0);
                            default: ;
                        endcase
                    end
                    default: begin
                        case ($urandom_range(0, 5))
                            0: push_text(CH_COMMA, 1'b1, 1'b0);
                            1: push_text(CH_LPAREN, 1'b1, 1'b0);
                            2: push_text(CH_RPAREN, 1'b1, 1'b0);
                            3: push_text(CH_STAR, 1'b1, 1'b0);
                            4: push_text(CH_MINUS, 1'b1, 1'b0);
                            default: push_text(CH_PLUS, 1'b1, 1'b0);
                        endcase
                    end
                endcase
                // Sprinkle stray bytes and empty transactions
                if ($urandom_range(0, 19) == 0)
                    push_text(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                if ($urandom_range(0, 19) == 0)
                    push_text(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        end
        // End the query on its last byte or with an end-only transaction
        if ($urandom_range(0, 1) == 0 && text_q.size() > first)
            text_q[text_q.size() - 1].eoq = 1'b1;
        else
            push_text(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endfunction

    // Send one transaction and queue its expected events on acceptance
    task automatic drive_text(t_text_row row);
        int unsigned gap;
        gap = draw_wait(tx_calm);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_text_byte    <= row.item.ch;
        i_has_byte     <= row.item.has;
        i_end_of_query <= row.item.eoq;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        lex_predict(row.item);
        if (row.typed) begin
            if (row.n_res)
                pending_events = {pending_events, row.res};
        end else begin
            foreach (step_events[k])
                pending_events = {pending_events, step_events[k]};
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt = mismatch_cnt + 1;
    endtask

    task automatic check_event();
        t_lex_event got, want;
        got = {o_event_res, o_token_kind, o_out_byte, o_error_code, o_last_result};
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event %0d kind %0d byte %h err %0d with none expected",
                                      got.ev, got.kind, got.data, got.err));
            return;
        end
        want = pending_events.pop_front();
        if (got.ev !== want.ev || got.kind !== want.kind || got.data !== want.data ||
            got.err !== want.err || got.last !== want.last)
            report_mismatch($sformatf({"got ev %0d kind %0d byte %h err %0d last %0d, ",
                                       "want ev %0d kind %0d byte %h err %0d last %0d"},
                got.ev, got.kind, got.data, got.err, got.last,
                want.ev, want.kind, want.data, want.err, want.last));
    endtask

    // Take output transactions and hold off the next one at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                check_event();
                rx_hold = draw_wait(rx_calm);
            end
            if (rx_hold != 0) begin
                i_stall <= 1'b1;
                rx_hold = rx_hold - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        t_text_row row;

        // Directed: error right after reset, drain, and end handling
        dir_known(8'h00, 1'b1, 1'b0, 1'b1, EV_ERR, NO_KIND, 8'h00, ERR_UNEXP);
        dir_known(CH_A_LO, 1'b1, 1'b1, 1'b0, EV_BYTE, NO_KIND, 8'h00, ERR_NONE);
        dir_known(8'hFF, 1'b0, 1'b1, 1'b1, EV_EOI, K_END, 8'h00, ERR_NONE);
        dir_known(8'hFF, 1'b0, 1'b0, 1'b0, EV_BYTE, NO_KIND, 8'h00, ERR_NONE);
        // Identifier opened by an underscore, continued by a dot and a digit, closed by punctuation
        dir_plain(CH_UNDER, 1'b1, 1'b0);
        dir_plain(CH_DOT, 1'b1, 1'b0);
        dir_plain(CH_9, 1'b1, 1'b0);
        dir_plain(CH_COMMA, 1'b1, 1'b0);
        // Number with both exponent marks and signs
        dir_plain(CH_0, 1'b1, 1'b0);
        dir_plain(CH_E_LO, 1'b1, 1'b0);
        dir_plain(CH_MINUS, 1'b1, 1'b0);
        dir_plain(CH_E_UP, 1'b1, 1'b0);
        dir_plain(CH_PLUS, 1'b1, 1'b0);
        // Operators: two-character pair, then one left open
        dir_plain(CH_LT, 1'b1, 1'b0);
        dir_plain(CH_GT, 1'b1, 1'b0);
        dir_plain(CH_BANG, 1'b1, 1'b0);
        // Token end, punctuation and end token in one transaction
        dir_plain(CH_LPAREN, 1'b1, 1'b1);
        // Empty string, then an unterminated one
        dir_plain(CH_SQUOTE, 1'b1, 1'b0);
        dir_plain(CH_SQUOTE, 1'b1, 1'b0);
        dir_plain(CH_DQUOTE, 1'b1, 1'b0);
        dir_plain(8'hFF, 1'b1, 1'b0);
        dir_plain(CH_SQUOTE, 1'b1, 1'b0);
        dir_known(8'h00, 1'b0, 1'b1, 1'b1, EV_ERR, NO_KIND, 8'h00, ERR_UNTERM);
        // Lone dot is an unexpected character
        dir_known(CH_DOT, 1'b1, 1'b0, 1'b1, EV_ERR, NO_KIND, CH_DOT, ERR_UNEXP);
        dir_known(8'h00, 1'b0, 1'b1, 1'b0, EV_BYTE, NO_KIND, 8'h00, ERR_NONE);
        dir_plain(CH_EQ, 1'b1, 1'b0);
        dir_plain(CH_EQ, 1'b1, 1'b0);
        dir_plain(CH_Z_LO, 1'b1, 1'b1);

        while (text_q.size() < RAND_ITEMS)
            gen_query();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            drive_text(dir_rows[k]);
        row = '0;
        foreach (text_q[k]) begin
            row.item = text_q[k];
            drive_text(row);
        end
        i_valid <= 1'b0;

        // Drain, then allow for stray late events
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
